// File: design/joint_trajectory_interpolator_assert.svh
// ----------------------------------------------------------------------------
// Joint trajectory interpolator assertion macros
// Shared property forms for the interpolator and its divider. Each use expects
// clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef JOINT_TRAJECTORY_INTERPOLATOR_ASSERT_SVH
`define JOINT_TRAJECTORY_INTERPOLATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define JTI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define JTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/jti_pkg.sv
// ----------------------------------------------------------------------------
// Joint trajectory interpolator package
// Field widths, register indexes and the divider request/response types.
// ----------------------------------------------------------------------------
`default_nettype none

package jti_pkg;

  localparam int NJ      = 3;
  localparam int ANG_W   = 17;
  localparam int POS_W   = 20;
  localparam int INC_W   = 18;
  localparam int LIM_W   = 16;
  localparam int STEP_W  = 10;
  localparam int PULSE_W = 12;
  localparam int DEG_W   = 8;
  localparam int CFG_DW  = 32;
  localparam int CFG_AW  = 5;
  localparam int REG_W   = 3;

  localparam logic [REG_W-1:0] REG_STEP_COUNT = 3'd0;
  localparam logic [REG_W-1:0] REG_HIP_LO     = 3'd1;
  localparam logic [REG_W-1:0] REG_HIP_HI     = 3'd2;
  localparam logic [REG_W-1:0] REG_KNEE_LO    = 3'd3;
  localparam logic [REG_W-1:0] REG_KNEE_HI    = 3'd4;
  localparam logic [REG_W-1:0] REG_ANKLE_LO   = 3'd5;
  localparam logic [REG_W-1:0] REG_ANKLE_HI   = 3'd6;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef logic [1:0]                joint_t;
  typedef logic signed [ANG_W-1:0]   angle_t;
  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic signed [INC_W-1:0]   inc_t;
  typedef logic signed [LIM_W-1:0]   lim_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic [PULSE_W-1:0]        pulse_t;

  typedef struct packed {
    logic  start;
    inc_t  dividend;
    step_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    inc_t quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: design/jti_if.sv
// ----------------------------------------------------------------------------
// Joint trajectory interpolator channels
// Request channel (start or tick) and pose channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface jti_req_if import jti_pkg::*;;
  logic   valid;
  logic   ready;
  logic   req_type;
  angle_t hip_from;
  angle_t hip_to;
  angle_t knee_from;
  angle_t knee_to;
  angle_t ankle_from;
  angle_t ankle_to;

  modport source (
    output valid, req_type, hip_from, hip_to, knee_from, knee_to, ankle_from, ankle_to,
    input  ready
  );
  modport sink (
    input  valid, req_type, hip_from, hip_to, knee_from, knee_to, ankle_from, ankle_to,
    output ready
  );
endinterface

interface jti_pose_if import jti_pkg::*;;
  logic   valid;
  logic   ready;
  pulse_t hip_pulse;
  pulse_t knee_pulse;
  pulse_t ankle_pulse;
  logic   last_pose;

  modport source (
    output valid, hip_pulse, knee_pulse, ankle_pulse, last_pose,
    input  ready
  );
  modport sink (
    input  valid, hip_pulse, knee_pulse, ankle_pulse, last_pose,
    output ready
  );
endinterface

`default_nettype wire

// File: design/joint_trajectory_interpolator.sv
// ----------------------------------------------------------------------------
// Joint trajectory interpolator
// Linear three-joint servo interpolator: start/tick requests in, pulse poses out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests. A start (req_type 0) loads the from/to angles of
//   hip, knee and ankle, derives the step count max(step_count, MIN_STEP_COUNT)
//   and the per-joint increments, then sends the first pose. Each tick
//   (req_type 1) sends the next pose; the final pose of a move has last_pose
//   set. A tick with no move running gives no pose.
//   out_ch carries poses as three servo pulse counts plus last_pose.
//   cfg_* is an APB-style register port: step count and joint limits.
// Sequence:
//   A start computes three increments in turn on the one shared bit-serial
//   divider, then passes one joint per cycle through the shared clamp/pulse
//   stage and then loads the output register. A tick is accepted, passes its
//   three joints through the same stage, and loads the output register.
//   in_ch.ready is high only while the sequencer is idle, one item at a time.
// Reset and stalls:
//   rst_n (synchronous) leaves the block idle with no move and the register
//   defaults loaded. A pose waits in the output register while out_ch.ready is
//   low; the next item may be accepted meanwhile and its pose holds back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "joint_trajectory_interpolator_assert.svh"

module joint_trajectory_interpolator import jti_pkg::*; #(
  parameter int MIN_STEP_COUNT = 10,
  parameter int PULSE_MIN      = 150,
  parameter int PULSE_MAX      = 600,
  parameter int FRAC_BITS      = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  jti_req_if.sink           in_ch,
  jti_pose_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CW    = 24;
  localparam int ONE   = 1 << FRAC_BITS;
  localparam int DEG_N = 181;

  localparam logic signed [CW-1:0] C90  = CW'(90 * ONE);
  localparam logic signed [CW-1:0] C180 = CW'(180 * ONE);
  localparam step_t  MIN_N      = STEP_W'(MIN_STEP_COUNT);
  localparam joint_t JOINT_LAST = joint_t'(NJ - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_LOAD = 3'd1;
  localparam logic [2:0] S_DIV      = 3'd2;
  localparam logic [2:0] S_MAP      = 3'd3;
  localparam logic [2:0] S_EMIT     = 3'd4;

  typedef pulse_t pulse_lut_t [0:DEG_N-1];

  function automatic pulse_lut_t build_lut();
    pulse_lut_t lut;
    int         p;
    for (int d = 0; d < DEG_N; d++) begin
      p      = PULSE_MIN + (d * (PULSE_MAX - PULSE_MIN)) / 180;
      lut[d] = PULSE_W'(p);
    end
    return lut;
  endfunction

  localparam pulse_lut_t PULSE_LUT = build_lut();

  // Configuration
  step_t step_count_r;
  lim_t  lim_lo_r [NJ];
  lim_t  lim_hi_r [NJ];

  // Move state
  logic [2:0] state_r, state_nxt;
  joint_t     jsel_r, jsel_nxt;
  pos_t       pos_r [NJ];
  inc_t       inc_r [NJ];
  angle_t     to_r  [NJ];
  step_t      steps_total_r;
  step_t      step_idx_r;
  logic       moving_r;
  logic       last_r;
  pulse_t     pulse_r [NJ];

  // Output register
  logic   out_valid_r;
  pulse_t out_hip_r, out_knee_r, out_ankle_r;
  logic   out_last_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             in_acc;
  logic             emit_go;
  logic             cfg_wr;
  logic [REG_W-1:0] cfg_idx;
  step_t            step_n;
  step_t            step_idx_nxt;

  pos_t                   pos_cur;
  inc_t                   inc_cur;
  angle_t                 to_cur;
  lim_t                   lo_cur, hi_cur;
  logic signed [CW-1:0]   ang, lo_b, hi_b, ang_l, ang_c;
  logic [DEG_W-1:0]       deg;
  pulse_t                 pulse_cur;
  pos_t                   pos_adv;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign emit_go      = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx      = cfg_paddr[CFG_AW-1:2];
  assign cfg_pready   = 1'b1;
  assign step_n       = (step_count_r < MIN_N) ? MIN_N : step_count_r;
  assign step_idx_nxt = step_idx_r + 1'b1;

  // Shared joint datapath, one joint per cycle
  always_comb begin
    pos_cur = pos_r[jsel_r];
    inc_cur = inc_r[jsel_r];
    to_cur  = to_r[jsel_r];
    lo_cur  = lim_lo_r[jsel_r];
    hi_cur  = lim_hi_r[jsel_r];
    ang     = {{(CW-POS_W){pos_cur[POS_W-1]}}, pos_cur};
    lo_b    = C90 + {{(CW-LIM_W){lo_cur[LIM_W-1]}}, lo_cur};
    hi_b    = C90 + {{(CW-LIM_W){hi_cur[LIM_W-1]}}, hi_cur};
    // with crossed limits, angles below lo_b get lo_b, all others hi_b
    if (ang < lo_b) begin
      ang_l = lo_b;
    end else if (ang > hi_b) begin
      ang_l = hi_b;
    end else begin
      ang_l = ang;
    end
    if (ang_l < 0) begin
      ang_c = '0;
    end else if (ang_l > C180) begin
      ang_c = C180;
    end else begin
      ang_c = ang_l;
    end
    deg       = ang_c[FRAC_BITS +: DEG_W];
    pulse_cur = PULSE_LUT[deg];
    pos_adv   = pos_cur + {{(POS_W-INC_W){inc_cur[INC_W-1]}}, inc_cur};
  end

  always_comb begin
    div_req.start    = (state_r == S_DIV_LOAD);
    div_req.dividend = {to_cur[ANG_W-1], to_cur} - pos_cur[INC_W-1:0];
    div_req.divisor  = steps_total_r;
  end

  jti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    jsel_nxt  = jsel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          jsel_nxt = '0;
          if (in_ch.req_type == REQ_START) begin
            state_nxt = S_DIV_LOAD;
          end else if (moving_r) begin
            state_nxt = S_MAP;
          end
        end
      end
      S_DIV_LOAD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (jsel_r == JOINT_LAST) begin
            jsel_nxt  = '0;
            state_nxt = S_MAP;
          end else begin
            jsel_nxt  = jsel_r + 1'b1;
            state_nxt = S_DIV_LOAD;
          end
        end
      end
      S_MAP: begin
        if (jsel_r == JOINT_LAST) begin
          jsel_nxt  = '0;
          state_nxt = S_EMIT;
        end else begin
          jsel_nxt = jsel_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        jsel_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      jsel_r        <= '0;
      moving_r      <= 1'b0;
      last_r        <= 1'b0;
      steps_total_r <= '0;
      step_idx_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      jsel_r  <= jsel_nxt;
      if ((state_r == S_IDLE) && in_acc) begin
        if (in_ch.req_type == REQ_START) begin
          steps_total_r <= step_n;
          step_idx_r    <= '0;
          moving_r      <= 1'b1;
          last_r        <= 1'b0;
        end else if (moving_r) begin
          step_idx_r <= step_idx_nxt;
          last_r     <= (step_idx_nxt == steps_total_r);
        end
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          moving_r <= 1'b0;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Joint payload
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_acc && (in_ch.req_type == REQ_START)) begin
      pos_r[0] <= {{(POS_W-ANG_W){in_ch.hip_from[ANG_W-1]}}, in_ch.hip_from};
      pos_r[1] <= {{(POS_W-ANG_W){in_ch.knee_from[ANG_W-1]}}, in_ch.knee_from};
      pos_r[2] <= {{(POS_W-ANG_W){in_ch.ankle_from[ANG_W-1]}}, in_ch.ankle_from};
      to_r[0]  <= in_ch.hip_to;
      to_r[1]  <= in_ch.knee_to;
      to_r[2]  <= in_ch.ankle_to;
    end else if (state_r == S_MAP) begin
      pulse_r[jsel_r] <= pulse_cur;
      // hold the final pose, advance otherwise
      if (!last_r) begin
        pos_r[jsel_r] <= pos_adv;
      end
    end
    if ((state_r == S_DIV) && div_rsp.done) begin
      inc_r[jsel_r] <= div_rsp.quot;
    end
    if (emit_go) begin
      out_hip_r   <= pulse_r[0];
      out_knee_r  <= pulse_r[1];
      out_ankle_r <= pulse_r[2];
      out_last_r  <= last_r;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.hip_pulse   = out_hip_r;
  assign out_ch.knee_pulse  = out_knee_r;
  assign out_ch.ankle_pulse = out_ankle_r;
  assign out_ch.last_pose   = out_last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= STEP_W'(125);
      for (int j = 0; j < NJ; j++) begin
        lim_lo_r[j] <= -LIM_W'(23040);
        lim_hi_r[j] <= LIM_W'(23040);
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_STEP_COUNT: step_count_r <= cfg_pwdata[STEP_W-1:0];
        REG_HIP_LO:     lim_lo_r[0]  <= cfg_pwdata[LIM_W-1:0];
        REG_HIP_HI:     lim_hi_r[0]  <= cfg_pwdata[LIM_W-1:0];
        REG_KNEE_LO:    lim_lo_r[1]  <= cfg_pwdata[LIM_W-1:0];
        REG_KNEE_HI:    lim_hi_r[1]  <= cfg_pwdata[LIM_W-1:0];
        REG_ANKLE_LO:   lim_lo_r[2]  <= cfg_pwdata[LIM_W-1:0];
        REG_ANKLE_HI:   lim_hi_r[2]  <= cfg_pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_STEP_COUNT: cfg_prdata = {{(CFG_DW-STEP_W){1'b0}}, step_count_r};
      REG_HIP_LO:     cfg_prdata = {{(CFG_DW-LIM_W){lim_lo_r[0][LIM_W-1]}}, lim_lo_r[0]};
      REG_HIP_HI:     cfg_prdata = {{(CFG_DW-LIM_W){lim_hi_r[0][LIM_W-1]}}, lim_hi_r[0]};
      REG_KNEE_LO:    cfg_prdata = {{(CFG_DW-LIM_W){lim_lo_r[1][LIM_W-1]}}, lim_lo_r[1]};
      REG_KNEE_HI:    cfg_prdata = {{(CFG_DW-LIM_W){lim_hi_r[1][LIM_W-1]}}, lim_hi_r[1]};
      REG_ANKLE_LO:   cfg_prdata = {{(CFG_DW-LIM_W){lim_lo_r[2][LIM_W-1]}}, lim_lo_r[2]};
      REG_ANKLE_HI:   cfg_prdata = {{(CFG_DW-LIM_W){lim_hi_r[2][LIM_W-1]}}, lim_hi_r[2]};
      default:        cfg_prdata = '0;
    endcase
  end

  `JTI_ASSERT_NOW(a_idx_bound, moving_r, step_idx_r <= steps_total_r, "step index past move length")
  `JTI_ASSERT_NOW(a_div_state, div_rsp.done, state_r == S_DIV, "divider result outside division")
  `JTI_ASSERT_NEXT(a_idle_tick, in_acc && (in_ch.req_type == REQ_TICK) && !moving_r, (state_r == S_IDLE) && !moving_r, "idle tick started work")
  `JTI_ASSERT_NEXT(a_last_stop, emit_go && last_r, !moving_r && out_ch.valid && out_ch.last_pose, "last pose left the move running")

endmodule

`default_nettype wire

// File: design/jti_div.sv
// ----------------------------------------------------------------------------
// Joint trajectory interpolator divider
// Signed by unsigned restoring divider, one quotient bit a cycle, quotient
// truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "joint_trajectory_interpolator_assert.svh"

module jti_div import jti_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int               CNT_W    = $clog2(INC_W);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(INC_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [STEP_W-1:0] rem_r;
  logic [INC_W-1:0]  quo_r;
  logic              neg_r;
  step_t             div_r;

  logic [STEP_W:0]   shifted;
  logic              fits;
  logic [STEP_W:0]   diff;
  logic [INC_W-1:0]  mag;

  always_comb begin
    shifted = {rem_r, quo_r[INC_W-1]};
    fits    = (shifted >= {1'b0, div_r});
    diff    = shifted - {1'b0, div_r};
    mag     = req.dividend[INC_W-1] ? (INC_W'(0) - req.dividend) : req.dividend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load the magnitude, then shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= mag;
      neg_r <= req.dividend[INC_W-1];
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
      quo_r <= {quo_r[INC_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? (INC_W'(0) - quo_r) : quo_r;

  `JTI_ASSERT_NEXT(a_start_busy, req.start, busy_r, "divider did not start")
  `JTI_ASSERT_NOW(a_done_end, done_r, $past(busy_r) && !busy_r, "done without a finished division")
  `JTI_ASSERT_NOW(a_rem_bound, busy_r, rem_r < div_r, "partial remainder not below divisor")

endmodule

`default_nettype wire
